// ----- sv/basis_to_quaternion_core_assert.svh -----
// Assertion macros for the basis-to-quaternion core.
`ifndef BASIS_TO_QUATERNION_CORE_ASSERT_SVH
`define BASIS_TO_QUATERNION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define B2Q_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("basis_to_quaternion_core: property violated");
`define B2Q_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("basis_to_quaternion_core: forbidden condition seen");
`else
`define B2Q_ASSERT(label, clk, rst_n, prop)
`define B2Q_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ----- sv/b2q_pkg.sv -----
// Shared types and constants of the basis-to-quaternion core.
`default_nettype none
package b2q_pkg;

	localparam int FRAC_BITS   = 14;
	localparam int ENT_W       = 16;
	localparam int RS_W        = ENT_W + 2;
	localparam int RAD_W       = RS_W - 1;
	localparam int D_W         = ENT_W + 1;
	localparam int SQ_W        = RAD_W + FRAC_BITS - 2;
	localparam int SQ_IN_W     = SQ_W + (SQ_W % 2);
	localparam int ROOT_W      = SQ_IN_W / 2;
	localparam int REM_W       = ROOT_W + 4;
	localparam int RR_W        = ROOT_W + 1;
	localparam int DEN_W       = RR_W + 2;
	localparam int Q_W         = ENT_W;
	localparam int NUM_W       = D_W + FRAC_BITS + 1;
	localparam int DIV_W       = DEN_W + Q_W - 1;
	localparam int CMP_W       = DEN_W + Q_W;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic signed [RS_W-1:0] RAD_ONE = RS_W'(1) <<< FRAC_BITS;
	localparam logic [Q_W-1:0] Q_POS_MAX = {1'b0, {(Q_W-1){1'b1}}};
	localparam logic [Q_W-1:0] Q_NEG_MAG = {1'b1, {(Q_W-1){1'b0}}};

	localparam logic [1:0] BR_W = 2'd0;
	localparam logic [1:0] BR_X = 2'd1;
	localparam logic [1:0] BR_Y = 2'd2;
	localparam logic [1:0] BR_Z = 2'd3;

	typedef struct packed {
		logic signed [ENT_W-1:0] x_axis_x;
		logic signed [ENT_W-1:0] x_axis_y;
		logic signed [ENT_W-1:0] x_axis_z;
		logic signed [ENT_W-1:0] y_axis_x;
		logic signed [ENT_W-1:0] y_axis_y;
		logic signed [ENT_W-1:0] y_axis_z;
		logic signed [ENT_W-1:0] z_axis_x;
		logic signed [ENT_W-1:0] z_axis_y;
		logic signed [ENT_W-1:0] z_axis_z;
	} in_item_t;

	typedef struct packed {
		logic signed [ENT_W-1:0] quat_w;
		logic signed [ENT_W-1:0] quat_x;
		logic signed [ENT_W-1:0] quat_y;
		logic signed [ENT_W-1:0] quat_z;
		logic [1:0]              branch_used;
		logic                    invalid;
	} out_item_t;

	typedef struct packed {
		logic                  invalid;
		logic [1:0]            branch;
		logic [RAD_W-1:0]      rad;
		logic signed [D_W-1:0] d0;
		logic signed [D_W-1:0] d1;
		logic signed [D_W-1:0] d2;
	} cls_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// ----- sv/b2q_front.sv -----
// Front end: takes a matrix transfer, picks the radicand branch and forms the differences or sums.
`default_nettype none
module b2q_front (
	input  logic                item_valid,
	output logic                item_ready,
	input  b2q_pkg::in_item_t   item,
	input  b2q_pkg::q_stat_t    q_stat,
	output logic                push,
	output b2q_pkg::cls_item_t  cls
);
	import b2q_pkg::*;

	logic signed [RS_W-1:0] m00, m11, m22;
	logic signed [RS_W-1:0] s_w, s_x, s_y, s_z;
	logic signed [D_W-1:0]  d_zy, d_xz, d_yx, a_xy, a_xz, a_yz;

	function automatic logic is_pos(input logic signed [RS_W-1:0] v);
		return !v[RS_W-1] && (v != '0);
	endfunction

	always_comb begin
		m00 = RS_W'(item.x_axis_x);
		m11 = RS_W'(item.y_axis_y);
		m22 = RS_W'(item.z_axis_z);
		s_w = m00 + m11 + m22 + RAD_ONE;
		s_x = m00 - m11 - m22 + RAD_ONE;
		s_y = m11 - m00 - m22 + RAD_ONE;
		s_z = m22 - m00 - m11 + RAD_ONE;

		// m21 - m12, m02 - m20, m10 - m01 and the matching sums.
		d_zy = D_W'(item.y_axis_z) - D_W'(item.z_axis_y);
		d_xz = D_W'(item.z_axis_x) - D_W'(item.x_axis_z);
		d_yx = D_W'(item.x_axis_y) - D_W'(item.y_axis_x);
		a_xy = D_W'(item.x_axis_y) + D_W'(item.y_axis_x);
		a_xz = D_W'(item.x_axis_z) + D_W'(item.z_axis_x);
		a_yz = D_W'(item.y_axis_z) + D_W'(item.z_axis_y);

		cls.invalid = 1'b0;
		if (is_pos(s_w)) begin
			cls.branch = BR_W;
			cls.rad    = s_w[RAD_W-1:0];
			cls.d0     = d_zy;
			cls.d1     = d_xz;
			cls.d2     = d_yx;
		end else if (is_pos(s_x)) begin
			cls.branch = BR_X;
			cls.rad    = s_x[RAD_W-1:0];
			cls.d0     = d_zy;
			cls.d1     = a_xy;
			cls.d2     = a_xz;
		end else if (is_pos(s_y)) begin
			cls.branch = BR_Y;
			cls.rad    = s_y[RAD_W-1:0];
			cls.d0     = d_xz;
			cls.d1     = a_xy;
			cls.d2     = a_yz;
		end else begin
			cls.branch = BR_Z;
			cls.rad    = s_z[RAD_W-1:0];
			cls.d0     = d_yx;
			cls.d1     = a_xz;
			cls.d2     = a_yz;
			if (!is_pos(s_z)) begin
				// No usable radicand: the back end turns this into zeros.
				cls.invalid = 1'b1;
				cls.rad     = '0;
			end
		end
	end

	assign item_ready = !q_stat.full;
	assign push       = item_valid && item_ready;

endmodule
`default_nettype wire

// ----- sv/b2q_queue.sv -----
// Short register queue between the classifying front end and the arithmetic back end.
`default_nettype none
module b2q_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  b2q_pkg::cls_item_t push_data,
	input  logic               pop,
	output b2q_pkg::cls_item_t head,
	output b2q_pkg::q_stat_t   q_stat
);
	import b2q_pkg::*;

	cls_item_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)  rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)      count_q <= count_q + QCNT_W'(1);
			else if (pop && !push) count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

	assign head         = entry_q[rd_ptr_q];
	assign q_stat.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (count_q == '0);

endmodule
`default_nettype wire

// ----- sv/b2q_back.sv -----
// Back end: pipelined square root, three pipelined dividers and the saturating output register.
`default_nettype none
module b2q_back (
	input  logic               clk,
	input  logic               arst_n,
	input  b2q_pkg::q_stat_t   q_stat,
	input  b2q_pkg::cls_item_t head,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_ready,
	output b2q_pkg::out_item_t result
);
	import b2q_pkg::*;

	logic en;

	// Square root stages, one root bit per stage.
	logic                sq_vld_s  [ROOT_W+1];
	logic [SQ_IN_W-1:0]  sq_v_s    [ROOT_W+1];
	logic [REM_W-1:0]    sq_rem_s  [ROOT_W+1];
	logic [ROOT_W-1:0]   sq_root_s [ROOT_W+1];
	cls_item_t           sq_cls_s  [ROOT_W+1];

	logic                vld_s16;
	logic [RR_W-1:0]     r_s16;
	cls_item_t           cls_s16;

	logic                vld_s17;
	logic [RR_W-1:0]     r_s17;
	logic [DEN_W-1:0]    den_s17;
	logic [NUM_W-1:0]    num_s17 [3];
	logic                neg_s17 [3];
	logic                inv_s17;
	logic [1:0]          br_s17;

	// Divider stages, one quotient bit per stage, three lanes.
	logic                dv_vld_s [Q_W+1];
	logic [DIV_W-1:0]    dv_rem_s [Q_W+1][3];
	logic [Q_W-1:0]      dv_quo_s [Q_W+1][3];
	logic                dv_ovf_s [Q_W+1][3];
	logic                dv_neg_s [Q_W+1][3];
	logic [DEN_W-1:0]    dv_den_s [Q_W+1];
	logic [RR_W-1:0]     dv_r_s   [Q_W+1];
	logic                dv_inv_s [Q_W+1];
	logic [1:0]          dv_br_s  [Q_W+1];

	logic                res_vld_q;
	out_item_t           result_q;
	out_item_t           res_next;
	logic [Q_W-1:0]      q_lane [3];
	logic [Q_W-1:0]      q_root;

	assign en  = !res_vld_q || result_ready;
	assign pop = en && !q_stat.empty;

	function automatic logic [Q_W-1:0] sat_root(input logic [RR_W-1:0] r);
		return (r > RR_W'(Q_POS_MAX)) ? Q_POS_MAX : Q_W'(r);
	endfunction

	function automatic logic [Q_W-1:0] sat_div(input logic [Q_W-1:0] quo, input logic ovf,
		input logic neg);
		logic [Q_W-1:0] v;
		if (neg) begin
			v = (ovf || quo > Q_NEG_MAG) ? Q_NEG_MAG : (~quo + Q_W'(1));
		end else begin
			v = (ovf || quo > Q_POS_MAX) ? Q_POS_MAX : quo;
		end
		return v;
	endfunction

	// Stage 0: load from the queue head.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else if (en) begin
			sq_vld_s[0] <= !q_stat.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_v_s[0]    <= SQ_IN_W'({head.rad, {(FRAC_BITS-2){1'b0}}});
			sq_rem_s[0]  <= '0;
			sq_root_s[0] <= '0;
			sq_cls_s[0]  <= head;
		end
	end

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic [REM_W-1:0] trial, sub;
		logic             ge;

		always_comb begin
			trial = {sq_rem_s[k][REM_W-3:0], sq_v_s[k][SQ_IN_W-1 -: 2]};
			sub   = REM_W'({sq_root_s[k], 2'b01});
			ge    = (trial >= sub);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				sq_vld_s[k+1] <= sq_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_v_s[k+1]    <= sq_v_s[k] << 2;
				sq_rem_s[k+1]  <= ge ? (trial - sub) : trial;
				sq_root_s[k+1] <= {sq_root_s[k][ROOT_W-2:0], ge};
				sq_cls_s[k+1]  <= sq_cls_s[k];
			end
		end
	end

	// Round the root to nearest, then set up the three numerators.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s16 <= 1'b0;
			vld_s17 <= 1'b0;
		end else if (en) begin
			vld_s16 <= sq_vld_s[ROOT_W];
			vld_s17 <= vld_s16;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s16   <= RR_W'(sq_root_s[ROOT_W]) +
				RR_W'(sq_rem_s[ROOT_W] > REM_W'(sq_root_s[ROOT_W]));
			cls_s16 <= sq_cls_s[ROOT_W];
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_num
		logic signed [D_W-1:0] d;
		logic [D_W-1:0]        mag;

		always_comb begin
			case (j)
				0:       d = cls_s16.d0;
				1:       d = cls_s16.d1;
				default: d = cls_s16.d2;
			endcase
			mag = d[D_W-1] ? D_W'(-d) : D_W'(d);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s17[j] <= (NUM_W'(mag) << FRAC_BITS) + NUM_W'({r_s16, 1'b0});
				neg_s17[j] <= d[D_W-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			r_s17   <= r_s16;
			den_s17 <= {r_s16, 2'b00};
			inv_s17 <= cls_s16.invalid;
			br_s17  <= cls_s16.branch;
		end
	end

	// Divider entry: catch quotients that cannot fit before the bit steps.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= vld_s17;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < 3; j++) begin
				dv_rem_s[0][j] <= DIV_W'(num_s17[j]);
				dv_quo_s[0][j] <= '0;
				dv_ovf_s[0][j] <= (CMP_W'(num_s17[j]) >= (CMP_W'(den_s17) << Q_W));
				dv_neg_s[0][j] <= neg_s17[j];
			end
			dv_den_s[0] <= den_s17;
			dv_r_s[0]   <= r_s17;
			dv_inv_s[0] <= inv_s17;
			dv_br_s[0]  <= br_s17;
		end
	end

	for (genvar i = 0; i < Q_W; i++) begin : g_div
		logic [DIV_W-1:0] shifted;
		logic             ge [3];

		always_comb begin
			shifted = DIV_W'(dv_den_s[i]) << (Q_W - 1 - i);
			for (int j = 0; j < 3; j++) ge[j] = (dv_rem_s[i][j] >= shifted);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[i+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[i+1] <= dv_vld_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int j = 0; j < 3; j++) begin
					dv_rem_s[i+1][j] <= ge[j] ? (dv_rem_s[i][j] - shifted) : dv_rem_s[i][j];
					dv_quo_s[i+1][j] <= {dv_quo_s[i][j][Q_W-2:0], ge[j]};
					dv_ovf_s[i+1][j] <= dv_ovf_s[i][j];
					dv_neg_s[i+1][j] <= dv_neg_s[i][j];
				end
				dv_den_s[i+1] <= dv_den_s[i];
				dv_r_s[i+1]   <= dv_r_s[i];
				dv_inv_s[i+1] <= dv_inv_s[i];
				dv_br_s[i+1]  <= dv_br_s[i];
			end
		end
	end

	// Place the root and the quotients by branch, or give zeros.
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			q_lane[j] = sat_div(dv_quo_s[Q_W][j], dv_ovf_s[Q_W][j], dv_neg_s[Q_W][j]);
		end
		q_root = sat_root(dv_r_s[Q_W]);
		res_next.branch_used = dv_br_s[Q_W];
		res_next.invalid     = dv_inv_s[Q_W];
		case (dv_br_s[Q_W])
			BR_W: begin
				res_next.quat_w = q_root;
				res_next.quat_x = q_lane[0];
				res_next.quat_y = q_lane[1];
				res_next.quat_z = q_lane[2];
			end
			BR_X: begin
				res_next.quat_w = q_lane[0];
				res_next.quat_x = q_root;
				res_next.quat_y = q_lane[1];
				res_next.quat_z = q_lane[2];
			end
			BR_Y: begin
				res_next.quat_w = q_lane[0];
				res_next.quat_x = q_lane[1];
				res_next.quat_y = q_root;
				res_next.quat_z = q_lane[2];
			end
			default: begin
				res_next.quat_w = q_lane[0];
				res_next.quat_x = q_lane[1];
				res_next.quat_y = q_lane[2];
				res_next.quat_z = q_root;
			end
		endcase
		if (dv_inv_s[Q_W]) begin
			res_next.quat_w      = '0;
			res_next.quat_x      = '0;
			res_next.quat_y      = '0;
			res_next.quat_z      = '0;
			res_next.branch_used = BR_Z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= dv_vld_s[Q_W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) result_q <= res_next;
	end

	assign result_valid = res_vld_q;
	assign result       = result_q;

endmodule
`default_nettype wire

// ----- sv/basis_to_quaternion_core.sv -----
// Throughput: one matrix per cycle unless stalled; the square root and the dividers are fully pipelined.
// Back-pressure stalls the whole back end; the two-entry queue accepts until it is full.
// Reset: arst_n clears all valid bits and queue pointers asynchronously; data is not reset.
// Top level of the basis-to-quaternion core: front end, queue and arithmetic back end.
`default_nettype none
`include "basis_to_quaternion_core_assert.svh"
module basis_to_quaternion_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  b2q_pkg::in_item_t  item,
	output logic               result_valid,
	input  logic               result_ready,
	output b2q_pkg::out_item_t result
);
	import b2q_pkg::*;

	// The front end classifies each transfer combinationally: it forms the four
	// radicands, keeps the first positive one (z is the fallback) and the three
	// matching differences or sums. The classified item lands in a short queue.
	// The back end pops the queue whenever its output register can advance, takes
	// the rounded square root one bit per stage, then divides the three numerators
	// by four times the root, one quotient bit per stage, and saturates.

	q_stat_t   q_stat;
	cls_item_t cls;
	cls_item_t head;
	logic      push;
	logic      pop;

	b2q_front u_front (
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_stat     (q_stat),
		.push       (push),
		.cls        (cls)
	);

	b2q_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (cls),
		.pop       (pop),
		.head      (head),
		.q_stat    (q_stat)
	);

	b2q_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	// An invalid result carries a zero quaternion and reports the z branch.
	`B2Q_ASSERT(a_invalid_zero, clk, arst_n, (result_valid && result.invalid) |-> (result.quat_w == '0 && result.quat_x == '0 && result.quat_y == '0 && result.quat_z == '0 && result.branch_used == BR_Z))
	// A valid w-branch result has a strictly positive scalar part.
	`B2Q_ASSERT(a_w_positive, clk, arst_n, (result_valid && !result.invalid && result.branch_used == BR_W) |-> (!result.quat_w[ENT_W-1] && result.quat_w != '0))
	// The queue cannot be full and empty at once.
	`B2Q_ASSERT_NEVER(a_queue_state, clk, arst_n, q_stat.full && q_stat.empty)

endmodule
`default_nettype wire
